/* design/elx_pkg.sv */
// Shared types and constants for the expression lexer.
// Holds the token kinds, character classes, widths and result records.
// No dependencies.
package elx_pkg;

  localparam int POSITION_BITS = 16;
  localparam int VALUE_BITS    = 32;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [VALUE_BITS-1:0]    val_t;

  typedef enum logic [3:0] {
    TOK_PLUS   = 4'd0,
    TOK_MINUS  = 4'd1,
    TOK_STAR   = 4'd2,
    TOK_SLASH  = 4'd3,
    TOK_LPAREN = 4'd4,
    TOK_RPAREN = 4'd5,
    TOK_NOT    = 4'd6,
    TOK_EQUAL  = 4'd7,
    TOK_NUMBER = 4'd8,
    TOK_IDENT  = 4'd9,
    TOK_INT    = 4'd10,
    TOK_IF     = 4'd11,
    TOK_PRINT  = 4'd12,
    TOK_SPACE  = 4'd13,
    TOK_BAD    = 4'd14,
    TOK_EOF    = 4'd15
  } tok_kind_e;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_DIGIT  = 2'd1,
    CLS_LETTER = 2'd2,
    CLS_SPACE  = 2'd3
  } char_class_e;

  typedef struct packed {
    tok_kind_e kind;
    pos_t      start;
    pos_t      length;
    val_t      value;
    logic      overflow;
    logic      last;
  } result_t;

  // Results produced by one accepted item, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* design/expression_lexer.sv */
// Streaming tokenizer: one text byte per transfer in, one token per transfer out.
// Throughput is one input transfer per cycle while the queue has room; results are
// registered in the result queue, and a two-token item leaves as two output transfers.
// Input stalls while the four-entry result queue has fewer than two free slots.
// Reset (asynchronous, active low) closes any open run and zeroes the position.
module expression_lexer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        char_code_i,
  input  logic                              ends_text_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [3:0]                        token_kind_o,
  output logic [elx_pkg::POSITION_BITS-1:0] start_position_o,
  output logic [elx_pkg::POSITION_BITS-1:0] token_length_o,
  output logic [elx_pkg::VALUE_BITS-1:0]    number_value_o,
  output logic                              number_overflow_o,
  output logic                              last_of_run_o
);
  import elx_pkg::*;

  char_class_e cls;
  tok_kind_e   op_kind;
  push_t       push;
  result_t     head;
  logic        accept;
  logic        pop;
  logic        full;

  // An input transfer happens whenever the queue can absorb the worst case
  // of two tokens; the run state is updated in the same cycle.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;
  assign pop        = out_valid_o && !out_stall_i;

  elx_classify u_classify (
    .char_code_i (char_code_i),
    .cls_o       (cls),
    .op_kind_o   (op_kind)
  );

  // The core flushes the open run before any operator, bad byte or
  // end-of-file token, so token order matches text order.
  elx_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .ends_text_i (ends_text_i),
    .cls_i       (cls),
    .op_kind_i   (op_kind),
    .push_o      (push)
  );

  // The queue separates the two sides, so a waiting result never blocks
  // the next input transfer while there is room.
  elx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign token_kind_o      = head.kind;
  assign start_position_o  = head.start;
  assign token_length_o    = head.length;
  assign number_value_o    = head.value;
  assign number_overflow_o = head.overflow;
  assign last_of_run_o     = head.last;

endmodule

/* design/elx_classify.sv */
// Character decoder for the expression lexer.
// Maps a text byte to its run class and, for single bytes, to a token kind.
// Depends on elx_pkg.
module elx_classify (
  input  logic [7:0]          char_code_i,
  output elx_pkg::char_class_e cls_o,
  output elx_pkg::tok_kind_e   op_kind_o
);
  import elx_pkg::*;

  always_comb begin
    unique case (char_code_i) inside
      [8'd48:8'd57]:                cls_o = CLS_DIGIT;
      [8'd65:8'd90], [8'd97:8'd122]: cls_o = CLS_LETTER;
      8'd32:                        cls_o = CLS_SPACE;
      default:                      cls_o = CLS_NONE;
    endcase
  end

  always_comb begin
    unique case (char_code_i)
      8'h2b:   op_kind_o = TOK_PLUS;
      8'h2d:   op_kind_o = TOK_MINUS;
      8'h2a:   op_kind_o = TOK_STAR;
      8'h2f:   op_kind_o = TOK_SLASH;
      8'h28:   op_kind_o = TOK_LPAREN;
      8'h29:   op_kind_o = TOK_RPAREN;
      8'h21:   op_kind_o = TOK_NOT;
      8'h3d:   op_kind_o = TOK_EQUAL;
      default: op_kind_o = TOK_BAD;
    endcase
  end

endmodule

/* design/elx_core.sv */
// Run tracking for the expression lexer: open run, number value, keyword
// match and character position. Emits up to two results per item.
// Depends on elx_pkg.
module elx_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           char_code_i,
  input  logic                 ends_text_i,
  input  elx_pkg::char_class_e cls_i,
  input  elx_pkg::tok_kind_e   op_kind_i,
  output elx_pkg::push_t       push_o
);
  import elx_pkg::*;

  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_P = 8'h70;
  localparam logic [7:0] CH_R = 8'h72;
  localparam pos_t POS_MAX = '1;
  localparam val_t VAL_MAX = '1;

  char_class_e run_class_q, run_class_d;
  pos_t        run_start_q, run_start_d;
  pos_t        run_count_q, run_count_d;
  val_t        acc_q, acc_d;
  logic        sat_q, sat_d;
  logic [2:0]  cand_q, cand_d;
  pos_t        char_index_q, char_index_d;

  // Bit 0 int, bit 1 if, bit 2 print: does byte c match at offset k.
  function automatic logic [2:0] kw_hit(pos_t k, logic [7:0] c);
    logic [2:0] h;
    h[0] = (k == pos_t'(0) && c == CH_I) || (k == pos_t'(1) && c == CH_N) ||
           (k == pos_t'(2) && c == CH_T);
    h[1] = (k == pos_t'(0) && c == CH_I) || (k == pos_t'(1) && c == CH_F);
    h[2] = (k == pos_t'(0) && c == CH_P) || (k == pos_t'(1) && c == CH_R) ||
           (k == pos_t'(2) && c == CH_I) || (k == pos_t'(3) && c == CH_N) ||
           (k == pos_t'(4) && c == CH_T);
    return h;
  endfunction

  logic                 run_open;
  logic                 extending;
  result_t              flush_res;
  result_t              single_res;
  pos_t                 base_count;
  val_t                 base_acc;
  logic                 base_sat;
  logic [2:0]           base_cand;
  logic [VALUE_BITS+3:0] times_ten;
  logic [3:0]           digit;

  assign run_open  = (run_class_q != CLS_NONE);
  assign extending = (cls_i != CLS_NONE) && (cls_i == run_class_q);
  assign digit     = char_code_i[3:0];

  // Token for the open run.
  always_comb begin
    flush_res          = '0;
    flush_res.start    = run_start_q;
    flush_res.length   = run_count_q;
    flush_res.kind     = TOK_IDENT;
    case (run_class_q)
      CLS_DIGIT: begin
        flush_res.kind     = TOK_NUMBER;
        flush_res.value    = acc_q;
        flush_res.overflow = sat_q;
      end
      CLS_SPACE: flush_res.kind = TOK_SPACE;
      default: begin
        if (cand_q[0] && run_count_q == pos_t'(3)) begin
          flush_res.kind = TOK_INT;
        end else if (cand_q[1] && run_count_q == pos_t'(2)) begin
          flush_res.kind = TOK_IF;
        end else if (cand_q[2] && run_count_q == pos_t'(5)) begin
          flush_res.kind = TOK_PRINT;
        end else begin
          flush_res.kind = TOK_IDENT;
        end
      end
    endcase
  end

  // Operator, bad byte or end-of-file token.
  always_comb begin
    single_res      = '0;
    single_res.last = 1'b1;
    single_res.start = char_index_q;
    if (ends_text_i) begin
      single_res.kind   = TOK_EOF;
      single_res.length = '0;
    end else begin
      single_res.kind   = op_kind_i;
      single_res.length = pos_t'(1);
    end
  end

  // Result ordering: the open run always goes first.
  always_comb begin
    push_o = '0;
    if (accept_i) begin
      if (ends_text_i || (!extending && cls_i == CLS_NONE)) begin
        if (run_open) begin
          push_o.count = 2'd2;
          push_o.first = flush_res;
          push_o.second = single_res;
        end else begin
          push_o.count = 2'd1;
          push_o.first = single_res;
        end
      end else if (!extending && run_open) begin
        push_o.count      = 2'd1;
        push_o.first      = flush_res;
        push_o.first.last = 1'b1;
      end
    end
  end

  // Extension of a run: either the current one or a freshly cleared one.
  always_comb begin
    if (extending) begin
      base_count = run_count_q;
      base_acc   = acc_q;
      base_sat   = sat_q;
      base_cand  = cand_q;
    end else begin
      base_count = '0;
      base_acc   = '0;
      base_sat   = 1'b0;
      base_cand  = 3'b111;
    end
    times_ten = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1) +
                (VALUE_BITS+4)'(digit);
  end

  always_comb begin
    run_class_d  = run_class_q;
    run_start_d  = run_start_q;
    run_count_d  = run_count_q;
    acc_d        = acc_q;
    sat_d        = sat_q;
    cand_d       = cand_q;
    char_index_d = char_index_q;
    if (accept_i) begin
      if (ends_text_i) begin
        run_class_d  = CLS_NONE;
        run_start_d  = '0;
        run_count_d  = '0;
        acc_d        = '0;
        sat_d        = 1'b0;
        cand_d       = 3'b111;
        char_index_d = '0;
      end else begin
        if (char_index_q != POS_MAX) begin
          char_index_d = char_index_q + pos_t'(1);
        end
        if (cls_i == CLS_NONE) begin
          run_class_d = CLS_NONE;
          run_start_d = '0;
          run_count_d = '0;
          acc_d       = '0;
          sat_d       = 1'b0;
          cand_d      = 3'b111;
        end else begin
          run_class_d = cls_i;
          if (!extending) begin
            run_start_d = char_index_q;
          end
          run_count_d = (base_count == POS_MAX) ? base_count : base_count + pos_t'(1);
          acc_d       = base_acc;
          sat_d       = base_sat;
          cand_d      = base_cand;
          if (cls_i == CLS_DIGIT && !base_sat) begin
            if (times_ten > {4'b0, VAL_MAX}) begin
              acc_d = VAL_MAX;
              sat_d = 1'b1;
            end else begin
              acc_d = times_ten[VALUE_BITS-1:0];
            end
          end
          if (cls_i == CLS_LETTER) begin
            cand_d = base_cand & kw_hit(base_count, char_code_i);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_class_q  <= CLS_NONE;
      run_start_q  <= '0;
      run_count_q  <= '0;
      acc_q        <= '0;
      sat_q        <= 1'b0;
      cand_q       <= 3'b111;
      char_index_q <= '0;
    end else begin
      run_class_q  <= run_class_d;
      run_start_q  <= run_start_d;
      run_count_q  <= run_count_d;
      acc_q        <= acc_d;
      sat_q        <= sat_d;
      cand_q       <= cand_d;
      char_index_q <= char_index_d;
    end
  end

endmodule

/* design/elx_fifo.sv */
// Result queue for the expression lexer: takes up to two results per cycle
// and hands out one per cycle unless stalled. Depends on elx_pkg.
module elx_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  elx_pkg::push_t   push_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output elx_pkg::result_t head_o
);
  import elx_pkg::*;

  result_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]    count_q, count_d;
  logic [FIFO_AW-1:0]  wr_next;

  assign wr_next = wr_ptr_q + FIFO_AW'(1);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // Room for two results is kept so that any item can be taken.
  assign full_o  = (count_q > (FIFO_AW+1)'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_AW'(push_i.count);
    rd_ptr_d = rd_ptr_q + FIFO_AW'(pop_i);
    count_d  = count_q + (FIFO_AW+1)'(push_i.count) - (FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* design/elx_checker.sv */
// Port-level checks for the expression lexer and the bind that attaches them.
// Depends on elx_pkg and expression_lexer.
module elx_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [3:0]                        token_kind_o,
  input logic [elx_pkg::POSITION_BITS-1:0] start_position_o,
  input logic [elx_pkg::POSITION_BITS-1:0] token_length_o,
  input logic [elx_pkg::VALUE_BITS-1:0]    number_value_o,
  input logic                              number_overflow_o,
  input logic                              last_of_run_o
);
  import elx_pkg::*;

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
    $stable(start_position_o) && $stable(number_value_o))
    else $error("stalled result changed");

  // End-of-file has no length and always closes its item.
  a_eof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == TOK_EOF |-> token_length_o == '0 && last_of_run_o)
    else $error("malformed end-of-file token");

  // Only number tokens carry a value or an overflow flag.
  a_value_only_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != TOK_NUMBER |-> number_value_o == '0 &&
    !number_overflow_o)
    else $error("value on a non-number token");

  // A saturated number sits at the maximum.
  a_overflow_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && number_overflow_o |-> number_value_o == '1)
    else $error("overflow without saturated value");

endmodule

bind expression_lexer elx_checker u_elx_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .token_kind_o      (token_kind_o),
  .start_position_o  (start_position_o),
  .token_length_o    (token_length_o),
  .number_value_o    (number_value_o),
  .number_overflow_o (number_overflow_o),
  .last_of_run_o     (last_of_run_o)
);

/* tb/tb_expression_lexer.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the expression lexer: drives text bytes, predicts every
// token with an in-bench tokenizer and compares each output transfer field by field.
// Depends on elx_pkg and expression_lexer only.
module tb_expression_lexer;
  import elx_pkg::*;

  localparam int IDLE_PCT    = 33;
  localparam int QUIET_LIMIT = 1000;

  // Bit positions of the keyword candidate mask.
  localparam int KW_INT   = 0;
  localparam int KW_IF    = 1;
  localparam int KW_PRINT = 2;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [7:0]               char_code_i = 8'd0;
  logic                     ends_text_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [3:0]               token_kind_o;
  logic [POSITION_BITS-1:0] start_position_o;
  logic [POSITION_BITS-1:0] token_length_o;
  logic [VALUE_BITS-1:0]    number_value_o;
  logic                     number_overflow_o;
  logic                     last_of_run_o;

  expression_lexer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_code_i      (char_code_i),
    .ends_text_i      (ends_text_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .token_kind_o     (token_kind_o),
    .start_position_o (start_position_o),
    .token_length_o   (token_length_o),
    .number_value_o   (number_value_o),
    .number_overflow_o(number_overflow_o),
    .last_of_run_o    (last_of_run_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Tokenizer state mirrored by the bench.
  char_class_e run_cls_q;
  pos_t        run_start_q;
  pos_t        run_len_q;
  val_t        run_value_q;
  bit          run_sat_q;
  bit [2:0]    kw_live_q;
  pos_t        char_pos_q;

  string kw_int_txt   = "int";
  string kw_if_txt    = "if";
  string kw_print_txt = "print";
  string op_chars     = "+-*/()!=";

  result_t step_tokens[$];
  result_t pending_tokens[$];

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int rx_hold_left = 0;
  int chars_sent = 0;
  int tokens_seen = 0;
  int errors = 0;
  int quiet_cycles = 0;

  function automatic char_class_e class_of_byte(input logic [7:0] c);
    if (c >= "0" && c <= "9") return CLS_DIGIT;
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return CLS_LETTER;
    if (c == " ") return CLS_SPACE;
    return CLS_NONE;
  endfunction

  function automatic tok_kind_e operator_token(input logic [7:0] c);
    case (c)
      "+": return TOK_PLUS;
      "-": return TOK_MINUS;
      "*": return TOK_STAR;
      "/": return TOK_SLASH;
      "(": return TOK_LPAREN;
      ")": return TOK_RPAREN;
      "!": return TOK_NOT;
      "=": return TOK_EQUAL;
      default: return TOK_BAD;
    endcase
  endfunction

  function automatic void emit_token(input tok_kind_e kind, input pos_t start,
                                     input pos_t length, input val_t value,
                                     input bit overflow);
    result_t t;
    t.kind     = kind;
    t.start    = start;
    t.length   = length;
    t.value    = value;
    t.overflow = overflow;
    t.last     = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void clear_open_run();
    run_cls_q   = CLS_NONE;
    run_start_q = '0;
    run_len_q   = '0;
    run_value_q = '0;
    run_sat_q   = 1'b0;
    kw_live_q   = 3'b111;
  endfunction

  // Closes the open run, if any, and turns it into its token.
  function automatic void flush_open_run();
    tok_kind_e kind;
    if (run_cls_q == CLS_NONE) return;
    kind = TOK_IDENT;
    if (run_cls_q == CLS_DIGIT) begin
      emit_token(TOK_NUMBER, run_start_q, run_len_q, run_value_q, run_sat_q);
    end else begin
      if (run_cls_q == CLS_SPACE) kind = TOK_SPACE;
      else if (kw_live_q[KW_INT] && run_len_q == 3) kind = TOK_INT;
      else if (kw_live_q[KW_IF] && run_len_q == 2) kind = TOK_IF;
      else if (kw_live_q[KW_PRINT] && run_len_q == 5) kind = TOK_PRINT;
      emit_token(kind, run_start_q, run_len_q, '0, 1'b0);
    end
    clear_open_run();
  endfunction

  // Adds one character to the open run: decimal value, keyword mask and length.
  function automatic void extend_open_run(input logic [7:0] c);
    longint unsigned digit;
    longint unsigned vmax;
    int k;
    k = int'(run_len_q);
    if (run_cls_q == CLS_DIGIT && !run_sat_q) begin
      digit = 64'(c) - 64'd48;
      vmax = 64'({VALUE_BITS{1'b1}});
      if (run_value_q > (vmax - digit) / 10) begin
        run_value_q = '1;
        run_sat_q   = 1'b1;
      end else begin
        run_value_q = val_t'(64'(run_value_q) * 64'd10 + digit);
      end
    end
    if (run_cls_q == CLS_LETTER) begin
      if (k >= 3 || c != kw_int_txt[k]) kw_live_q[KW_INT] = 1'b0;
      if (k >= 2 || c != kw_if_txt[k]) kw_live_q[KW_IF] = 1'b0;
      if (k >= 5 || c != kw_print_txt[k]) kw_live_q[KW_PRINT] = 1'b0;
    end
    if (run_len_q != '1) run_len_q++;
  endfunction

  // Works out the tokens caused by one accepted byte and queues them.
  function automatic void tokenize_byte(input logic [7:0] c, input bit ends);
    char_class_e cls;
    step_tokens.delete();
    if (ends) begin
      flush_open_run();
      emit_token(TOK_EOF, char_pos_q, '0, '0, 1'b0);
      clear_open_run();
      char_pos_q = '0;
    end else begin
      cls = class_of_byte(c);
      if (cls != CLS_NONE && cls == run_cls_q) begin
        extend_open_run(c);
      end else begin
        flush_open_run();
        if (cls != CLS_NONE) begin
          run_cls_q   = cls;
          run_start_q = char_pos_q;
          extend_open_run(c);
        end else begin
          emit_token(operator_token(c), char_pos_q, pos_t'(1), '0, 1'b0);
        end
      end
      if (char_pos_q != '1) char_pos_q++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  // One input transfer. Starts at a falling edge and returns at the accepting rising
  // edge, so back-to-back calls keep valid high without touching it twice in a step.
  task automatic send_item(input logic [7:0] c, input bit ends);
    @(negedge clk_i);
    while (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i  <= 1'b0;
      char_code_i <= 8'($urandom_range(255));
      ends_text_i <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    ends_text_i <= ends;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tokenize_byte(c, ends);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic end_text();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Lowers valid and waits until every queued token has been delivered.
  task automatic drain_tokens();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  // One piece of plausible source text with random content; a small share is noise.
  task automatic send_random_piece();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 20) begin
      case ($urandom_range(7))
        0, 1: send_text("int");
        2, 3: send_text("if");
        4, 5: send_text("print");
        6:    send_text("prin");
        default: send_text("iF");
      endcase
    end else if (pick < 38) begin
      n = $urandom_range(1, 6);
      repeat (n) send_item(8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25)), 1'b0);
    end else if (pick < 58) begin
      case ($urandom_range(7))
        0: send_text("4294967295");
        1: send_text("4294967296");
        2, 3: begin
          n = $urandom_range(9, 13);
          repeat (n) send_item(8'("0" + $urandom_range(9)), 1'b0);
        end
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) send_item(8'("0" + $urandom_range(9)), 1'b0);
        end
      endcase
    end else if (pick < 78) begin
      send_item(op_chars[$urandom_range(7)], 1'b0);
    end else if (pick < 87) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(" ", 1'b0);
    end else if (pick < 95) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(8'($urandom_range(255)), 1'b0);
    end else begin
      end_text();
    end
  endtask

  task automatic send_random_text(input int count);
    int target;
    target = chars_sent + count;
    while (chars_sent < target) send_random_piece();
  endtask

  // Every token kind once, including both bad-byte extremes, then end of text with no
  // run open.
  task automatic test_every_token_kind();
    send_text("print(x-int)*if/ 7=!+");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    end_text();
  endtask

  // A digit run past the value maximum, closed by end of text.
  task automatic test_number_overflow();
    send_text("9999999999");
    end_text();
  endtask

  task automatic test_random_text();
    send_random_text(100);
  endtask

  // The receiver holds off long enough for the result queue to fill and the input to
  // stall, while the sender keeps offering operators.
  task automatic test_output_backpressure();
    rx_hold_left = 50;
    repeat (20) send_item(op_chars[$urandom_range(7)], 1'b0);
    send_random_text(20);
  endtask

  task automatic test_steady_stream();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_random_text(100);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // The sender stops until all tokens are out, then resumes mid-text.
  task automatic test_pause_until_drained();
    send_random_text(20);
    drain_tokens();
    send_random_text(100);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_stall_i <= 1'b1;
        rx_hold_left--;
      end else if (rx_gaps) begin
        out_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_tokens
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        errors++;
        $display("%0t: token with nothing expected, expected none, actual kind %0d",
                 $time, token_kind_o);
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 64'(want.kind), 64'(token_kind_o));
        check_field("start_position", 64'(want.start), 64'(start_position_o));
        check_field("token_length", 64'(want.length), 64'(token_length_o));
        check_field("number_value", 64'(want.value), 64'(number_value_o));
        check_field("number_overflow", 64'(want.overflow), 64'(number_overflow_o));
        check_field("last_of_run", 64'(want.last), 64'(last_of_run_o));
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d tokens outstanding",
                 $time, QUIET_LIMIT, pending_tokens.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    clear_open_run();
    char_pos_q = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_every_token_kind();
    test_number_overflow();
    test_random_text();
    test_output_backpressure();
    test_steady_stream();
    test_pause_until_drained();

    drain_tokens();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d characters and checked %0d tokens, %0d mismatches.",
             chars_sent, tokens_seen, errors);
    $display("Covered all token kinds, value overflow, keyword edges and backpressure.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* expression_lexer.f */
design/elx_pkg.sv
design/elx_classify.sv
design/elx_core.sv
design/elx_fifo.sv
design/expression_lexer.sv
design/elx_checker.sv
tb/tb_expression_lexer.sv
